// ===== hdl/vrpd_pkg.sv =====
// Package for the vertical run pixel darken unit.
// Holds the shared constants, the item and store word types and the darker value function.
// No dependencies.
package vrpd_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 12;
  localparam int HGT_W     = 16;
  localparam int ROW_W     = HGT_W + 1;
  localparam int PIX_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [WID_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 16'd480;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic             flag;
    logic             in_window;
    logic             emit;
    logic             done;
  } item_t;

  typedef struct packed {
    logic   valid;
    item_t  item;
  } q_head_t;

  // One column of the row stores: final rows above, raw centre and raw row below.
  typedef struct packed {
    logic [PIX_W-1:0] f2;
    logic [PIX_W-1:0] f1;
    logic [PIX_W-1:0] rc;
    logic             rcf;
    logic [PIX_W-1:0] rb;
    logic             rbf;
  } col_word_t;

  localparam int WORD_W = $bits(col_word_t);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_done;
  } result_t;

  function automatic logic [PIX_W-1:0] darker_value(input logic [PIX_W-1:0] thr);
    logic [7:0] c2;
    c2 = {1'b0, thr[7:1]};
    return 32'h0000_00FF + {8'h00, c2, c2, c2};
  endfunction

endpackage

// ===== hdl/vrpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module vrpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/vrpd_front.sv =====
// Front end: tracks the raster position, accepts beats and classifies each item.
// Depends on vrpd_pkg.
module vrpd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic                        in_cmd,
  input  logic [vrpd_pkg::PIX_W-1:0]  in_pixel,
  input  logic                        in_component,
  input  logic [vrpd_pkg::WID_W-1:0]  image_width,
  input  logic [vrpd_pkg::HGT_W-1:0]  image_height,
  input  logic                        q_full,
  output logic                        q_push,
  output vrpd_pkg::item_t             q_item
);

  logic [vrpd_pkg::COL_W-1:0] col_r, col_nxt;
  logic [vrpd_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [vrpd_pkg::WID_W-1:0] w_eff;
  logic [vrpd_pkg::HGT_W-1:0] h_eff;
  logic                       wrap_col, wrap_row, col_ok, row_ok;

  always_comb begin
    if (image_width == '0) begin
      w_eff = vrpd_pkg::WID_W'(1);
    end else if (image_width > vrpd_pkg::WID_W'(vrpd_pkg::MAX_WIDTH)) begin
      w_eff = vrpd_pkg::WID_W'(vrpd_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? vrpd_pkg::HGT_W'(1) : image_height;

    // Positions at or past a shrunken end wrap as if they were the last one.
    wrap_col = ({1'b0, col_r} + 12'd1) >= w_eff;
    wrap_row = ({1'b0, row_r} + 18'd1) >= ({2'b00, h_eff} + 18'd2);
    col_ok   = (col_r != '0) && (({2'b00, col_r} + 13'd2) <= {1'b0, w_eff});
    row_ok   = (row_r >= vrpd_pkg::ROW_W'(4)) &&
               (({1'b0, row_r} + 18'd1) <= {2'b00, h_eff});

    q_push           = push && !q_full;
    q_item.col       = col_r;
    q_item.pix       = (in_cmd == vrpd_pkg::CMD_DRAIN) ? '0 : in_pixel;
    q_item.flag      = (in_cmd == vrpd_pkg::CMD_DRAIN) ? 1'b0 : in_component;
    q_item.in_window = col_ok && row_ok;
    q_item.emit      = row_r >= vrpd_pkg::ROW_W'(2);
    q_item.done      = wrap_col && wrap_row;

    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push) begin
      if (wrap_col) begin
        col_nxt = '0;
        row_nxt = wrap_row ? '0 : row_r + vrpd_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + vrpd_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== hdl/vrpd_queue.sv =====
// Short queue of classified items between the front end and the back end.
// Depends on vrpd_pkg.
module vrpd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  vrpd_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd_en,
  output vrpd_pkg::q_head_t head
);

  vrpd_pkg::item_t           slot_r [vrpd_pkg::Q_DEPTH];
  logic [vrpd_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [vrpd_pkg::Q_AW:0]   count_r, count_nxt;

  always_comb begin
    full       = count_r == (vrpd_pkg::Q_AW+1)'(vrpd_pkg::Q_DEPTH);
    head.valid = count_r != '0;
    head.item  = slot_r[rd_ptr_r];
    wr_ptr_nxt = wr_en ? wr_ptr_r + vrpd_pkg::Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + vrpd_pkg::Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (vrpd_pkg::Q_AW+1)'(wr_en) - (vrpd_pkg::Q_AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/vrpd_back.sv =====
// Back end: read-modify-write of the row stores, the five-pixel test and the result queue.
// Depends on vrpd_pkg and vrpd_ram.
module vrpd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [vrpd_pkg::PIX_W-1:0] threshold,
  input  vrpd_pkg::q_head_t          head,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [vrpd_pkg::PIX_W-1:0] out_pixel,
  output logic                       out_frame_done
);

  vrpd_pkg::item_t           b_item_r;
  logic                      b_valid_r, b_valid_nxt, b_fire;
  logic                      fwd_r;
  vrpd_pkg::col_word_t       fwd_word_r;
  logic [vrpd_pkg::WORD_W-1:0] rdata;
  vrpd_pkg::col_word_t       cur, upd;
  logic                      hit;
  logic [vrpd_pkg::PIX_W-1:0] result;
  logic                      o_full, o_push;

  vrpd_pkg::result_t         o_slot_r [vrpd_pkg::Q_DEPTH];
  logic [vrpd_pkg::Q_AW-1:0] o_wr_r, o_wr_nxt, o_rd_r, o_rd_nxt;
  logic [vrpd_pkg::Q_AW:0]   o_cnt_r, o_cnt_nxt;
  logic                      o_pop;
  vrpd_pkg::result_t         o_head;

  vrpd_ram #(
    .WIDTH (vrpd_pkg::WORD_W),
    .DEPTH (vrpd_pkg::MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (b_fire),
    .waddr (b_item_r.col),
    .wdata (upd),
    .re    (q_pop),
    .raddr (head.item.col),
    .rdata (rdata)
  );

  always_comb begin
    // The RAM returns old data when the column read now is the one being written;
    // in that case the written word is kept and used instead.
    cur    = fwd_r ? fwd_word_r : vrpd_pkg::col_word_t'(rdata);
    hit    = b_item_r.in_window && cur.rcf &&
             (cur.rc >= threshold) && (cur.f1 >= threshold) &&
             (cur.f2 >= threshold) && (cur.rb >= threshold) &&
             (b_item_r.pix >= threshold);
    result = hit ? vrpd_pkg::darker_value(threshold) : cur.rc;

    upd.f2  = cur.f1;
    upd.f1  = result;
    upd.rc  = cur.rb;
    upd.rcf = cur.rbf;
    upd.rb  = b_item_r.pix;
    upd.rbf = b_item_r.flag;

    o_full      = o_cnt_r == (vrpd_pkg::Q_AW+1)'(vrpd_pkg::Q_DEPTH);
    b_fire      = b_valid_r && (!b_item_r.emit || !o_full);
    o_push      = b_fire && b_item_r.emit;
    q_pop       = head.valid && (!b_valid_r || b_fire);
    b_valid_nxt = q_pop || (b_valid_r && !b_fire);

    empty          = o_cnt_r == '0;
    o_pop          = pop && !empty;
    o_head         = o_slot_r[o_rd_r];
    out_pixel      = o_head.pixel;
    out_frame_done = o_head.frame_done;
    o_wr_nxt  = o_push ? o_wr_r + vrpd_pkg::Q_AW'(1) : o_wr_r;
    o_rd_nxt  = o_pop ? o_rd_r + vrpd_pkg::Q_AW'(1) : o_rd_r;
    o_cnt_nxt = o_cnt_r + (vrpd_pkg::Q_AW+1)'(o_push) - (vrpd_pkg::Q_AW+1)'(o_pop);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item_r   <= head.item;
      fwd_r      <= b_fire && (b_item_r.col == head.item.col);
      fwd_word_r <= upd;
    end
    if (o_push) begin
      o_slot_r[o_wr_r] <= '{pixel: result, frame_done: b_item_r.done};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      o_wr_r    <= '0;
      o_rd_r    <= '0;
      o_cnt_r   <= '0;
    end else begin
      b_valid_r <= b_valid_nxt;
      o_wr_r    <= o_wr_nxt;
      o_rd_r    <= o_rd_nxt;
      o_cnt_r   <= o_cnt_nxt;
    end
  end

endmodule

// ===== hdl/vertical_run_pixel_darken_unit.sv =====
// Top level of the vertical run pixel darken unit: configuration registers and wiring.
// Depends on vrpd_pkg, vrpd_front, vrpd_queue and vrpd_back. One beat per cycle each side
// while full and empty are low. A result belongs to the pixel accepted two rows
// (2 * width items) earlier, and the first two rows give none.
// Reset clears the position, the queues and the registers (threshold 0, width 640,
// height 480); the row stores are not cleared and need no clearing pass.
module vertical_run_pixel_darken_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic                           in_cmd,
  input  logic [vrpd_pkg::PIX_W-1:0]     in_pixel,
  input  logic                           in_component,
  output logic                           empty,
  input  logic                           pop,
  output logic [vrpd_pkg::PIX_W-1:0]     out_pixel,
  output logic                           out_frame_done,
  input  logic                           cfg_we,
  input  logic [vrpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vrpd_pkg::PIX_W-1:0]     cfg_wdata
);

  logic [vrpd_pkg::PIX_W-1:0] threshold_r;
  logic [vrpd_pkg::WID_W-1:0] width_r;
  logic [vrpd_pkg::HGT_W-1:0] height_r;
  logic                       q_push, q_pop;
  vrpd_pkg::item_t            q_item;
  vrpd_pkg::q_head_t          q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      width_r     <= vrpd_pkg::WIDTH_RESET;
      height_r    <= vrpd_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vrpd_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata;
        vrpd_pkg::CFG_WIDTH:     width_r     <= cfg_wdata[vrpd_pkg::WID_W-1:0];
        vrpd_pkg::CFG_HEIGHT:    height_r    <= cfg_wdata[vrpd_pkg::HGT_W-1:0];
        default: ;
      endcase
    end
  end

  vrpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_cmd       (in_cmd),
    .in_pixel     (in_pixel),
    .in_component (in_component),
    .image_width  (width_r),
    .image_height (height_r),
    .q_full       (full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  vrpd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (q_item),
    .full    (full),
    .rd_en   (q_pop),
    .head    (q_head)
  );

  vrpd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .threshold      (threshold_r),
    .head           (q_head),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_pixel      (out_pixel),
    .out_frame_done (out_frame_done)
  );

endmodule

// ===== hdl/vrpd_checker.sv =====
// Port-level checks for the vertical run pixel darken unit, bound to the top level.
// Depends on vrpd_pkg and vertical_run_pixel_darken_unit.
module vrpd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           push,
  input logic                           full,
  input logic                           in_cmd,
  input logic [vrpd_pkg::PIX_W-1:0]     in_pixel,
  input logic                           in_component,
  input logic                           empty,
  input logic                           pop,
  input logic [vrpd_pkg::PIX_W-1:0]     out_pixel,
  input logic                           out_frame_done,
  input logic                           cfg_we,
  input logic [vrpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [vrpd_pkg::PIX_W-1:0]     cfg_wdata
);

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // The input side can only fill up through an accepted beat.
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    !full && !push |=> !full)
    else $error("full rose without an input beat");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty)
    else $error("waiting result withdrawn");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> $stable(out_pixel) && $stable(out_frame_done))
    else $error("waiting result changed");

endmodule

bind vertical_run_pixel_darken_unit vrpd_checker u_vrpd_checker (.*);
